// File: hdl/fra_pkg.sv
// Shared constants, status codes and unit status type for the Farey approximation block.
package fra_pkg;

	localparam int DENOM_BITS_DEF = 20;
	localparam int FRAC_BITS_DEF  = 40;
	localparam int MAX_ITER_DEF   = 100;

	// floor epsilon of the step count, 2^-EPS_SHIFT
	localparam int EPS_SHIFT = 33;

	localparam int ITER_W = 7;
	localparam int STAT_W = 2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_ABOVE = 2'd1;
	localparam logic [STAT_W-1:0] ST_BELOW = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

// File: hdl/fra_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
module fra_mul
	import fra_pkg::*;
#(
	parameter int PW = 84,
	parameter int MB = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [PW-1:0] mcand,
	input  logic [MB-1:0] mplier,
	output logic [PW-1:0] prod,
	output unit_sts_t     sts
);

	localparam int CW = $clog2(MB + 1);

	logic [PW-1:0] acc_q;
	logic [PW-1:0] mc_q;
	logic [MB-1:0] mp_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(MB);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= mcand;
			mp_q  <= mplier;
		end else if (busy_q) begin
			if (mp_q[0])
				acc_q <= acc_q + mc_q;
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign prod     = acc_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

// File: hdl/fra_div.sv
// Restoring divider, one quotient bit per cycle; dividend must be below divisor << QB.
module fra_div
	import fra_pkg::*;
#(
	parameter int PW = 84,
	parameter int QB = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [PW-1:0] dividend,
	input  logic [PW-1:0] divisor,
	output logic [QB-1:0] quo,
	output logic [PW-1:0] rem,
	output unit_sts_t     sts
);

	localparam int CW = $clog2(QB + 1);

	logic [PW-1:0] rem_q;
	logic [PW-1:0] dvs_q;
	logic [QB-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          ge;

	assign ge = rem_q >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(QB);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor << (QB - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dvs_q;
			quo_q <= {quo_q[QB-2:0], ge};
			dvs_q <= dvs_q >> 1;
		end
	end

	assign quo      = quo_q;
	assign rem      = rem_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

// File: hdl/fra_seq.sv
// Sequencer and endpoint registers of the mediant search, sharing one multiplier and one divider.
module fra_seq
	import fra_pkg::*;
#(
	parameter int DENOM_BITS = DENOM_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int MAX_ITER   = MAX_ITER_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FRAC_BITS+2:0]  target,
	input  logic [DENOM_BITS-1:0] max_den,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [DENOM_BITS-1:0] res_num,
	output logic [DENOM_BITS-1:0] res_den,
	output logic [ITER_W-1:0]     res_iter,
	output logic [STAT_W-1:0]     res_stat
);

	localparam int DB  = DENOM_BITS;
	localparam int FB  = FRAC_BITS;
	localparam int TW  = FB + 3;
	localparam int PW  = FB + 2 * DB + 4;
	localparam int MB  = DB + 4;
	localparam int IWC = $clog2(MAX_ITER + 2);
	localparam int IW  = (IWC > ITER_W) ? IWC : ITER_W;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_TB    = 14'b00000000000010,
		S_TD    = 14'b00000000000100,
		S_CHECK = 14'b00000000001000,
		S_QCHK  = 14'b00000000010000,
		S_CAP   = 14'b00000000100000,
		S_STEP  = 14'b00000001000000,
		S_SDIV  = 14'b00000010000000,
		S_UPD1  = 14'b00000100000000,
		S_UPD2  = 14'b00001000000000,
		S_FIN1  = 14'b00010000000000,
		S_FIN2  = 14'b00100000000000,
		S_FIN3  = 14'b01000000000000,
		S_DONE  = 14'b10000000000000
	} seq_state_t;

	seq_state_t    state_q;
	logic          launched_q;
	logic          left_q;
	logic [DB-1:0] a_q, b_q, c_q, d_q, m_q, cap_q, n_q;
	logic [FB:0]   t_q;
	logic [PW-1:0] tb_q, td_q, qd_q, num_q, lhs_q, s1_q;
	logic [IW-1:0] ii_q;
	logic [DB-1:0] rn_q, rd_q;
	logic [STAT_W-1:0] st_q;

	logic          mul_start, div_start;
	logic [PW-1:0] mul_mc, mul_prod, div_n, div_d, div_rem;
	logic [MB-1:0] mul_mp;
	logic [DB-1:0] div_quo;
	unit_sts_t     mul_sts, div_sts;

	logic [PW-1:0] af, cf, acf, one_w, sum_w, e_w, rhs_w;
	logic [DB:0]   bd_w, q1_w;
	logic [MB-1:0] m10_w;
	logic [DB-1:0] m_in, n_sd;
	logic          inc_w;

	assign af    = PW'(a_q) << FB;
	assign cf    = PW'(c_q) << FB;
	assign acf   = PW'({1'b0, a_q} + {1'b0, c_q}) << FB;
	assign one_w = PW'(1) << FB;
	assign sum_w = tb_q + td_q;
	assign bd_w  = {1'b0, b_q} + {1'b0, d_q};
	assign m10_w = (MB'(m_q) << 3) + (MB'(m_q) << 1);
	assign m_in  = (max_den == '0) ? DB'(1) : max_den;

	// step count: floor plus epsilon, clamped to the cap
	assign e_w   = qd_q - div_rem;
	assign inc_w = e_w <= (qd_q >> EPS_SHIFT);
	assign q1_w  = {1'b0, div_quo} + (DB + 1)'(inc_w);
	assign n_sd  = (q1_w > {1'b0, cap_q}) ? cap_q : q1_w[DB-1:0];
	assign rhs_w = (s1_q + mul_prod) << FB;

	always_comb begin
		mul_mc    = '0;
		mul_mp    = '0;
		div_n     = '0;
		div_d     = '0;
		case (state_q)
			S_TB: begin
				mul_mc = PW'(t_q);
				mul_mp = MB'(b_q);
			end
			S_TD: begin
				mul_mc = PW'(t_q);
				mul_mp = MB'(d_q);
			end
			S_QCHK: begin
				mul_mc = qd_q;
				mul_mp = m10_w;
			end
			S_CAP: begin
				if (left_q) begin
					div_n = (m_q > d_q) ? PW'(m_q - d_q) : '0;
					div_d = PW'(b_q);
				end else begin
					div_n = (m_q > b_q) ? PW'(m_q - b_q) : '0;
					div_d = PW'(d_q);
				end
			end
			S_SDIV: begin
				div_n = num_q;
				div_d = qd_q;
			end
			S_UPD1: begin
				mul_mc = PW'(n_q);
				mul_mp = MB'(left_q ? a_q : c_q);
			end
			S_UPD2: begin
				mul_mc = PW'(n_q);
				mul_mp = MB'(left_q ? b_q : d_q);
			end
			S_FIN1: begin
				mul_mc = tb_q;
				mul_mp = MB'(d_q);
			end
			S_FIN2: begin
				mul_mc = PW'(a_q);
				mul_mp = MB'(d_q);
			end
			S_FIN3: begin
				mul_mc = PW'(c_q);
				mul_mp = MB'(b_q);
			end
			default: begin
			end
		endcase
		mul_start = !launched_q && (state_q inside {S_TB, S_TD, S_QCHK, S_UPD1, S_UPD2,
			S_FIN1, S_FIN2, S_FIN3});
		div_start = !launched_q && (state_q inside {S_CAP, S_SDIV});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			launched_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (target[TW-1])
							state_q <= S_DONE;
						else if (target > (TW'(1) << FB))
							state_q <= S_DONE;
						else
							state_q <= S_TB;
					end
				end
				S_TB, S_TD, S_QCHK, S_UPD1, S_UPD2, S_FIN1, S_FIN2, S_FIN3: begin
					if (!launched_q) begin
						launched_q <= 1'b1;
					end else if (mul_sts.done) begin
						launched_q <= 1'b0;
						case (state_q)
							S_TB:    state_q <= S_TD;
							S_TD:    state_q <= S_CHECK;
							S_QCHK:  state_q <= (mul_prod < one_w) ? S_DONE : S_CAP;
							S_UPD1:  state_q <= S_UPD2;
							S_UPD2:  state_q <= S_TB;
							S_FIN1:  state_q <= S_FIN2;
							S_FIN2:  state_q <= S_FIN3;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CAP, S_SDIV: begin
					if (!launched_q) begin
						launched_q <= 1'b1;
					end else if (div_sts.done) begin
						launched_q <= 1'b0;
						state_q    <= (state_q == S_CAP) ? S_STEP : S_UPD1;
					end
				end
				S_CHECK: begin
					if (bd_w > {1'b0, m_q} || ii_q > IW'(MAX_ITER))
						state_q <= S_FIN1;
					else if (sum_w < acf)
						state_q <= (tb_q <= af) ? S_DONE : S_QCHK;
					else
						state_q <= (cf <= td_q) ? S_DONE : S_QCHK;
				end
				S_STEP: begin
					if (num_q == '0 || num_q >= (qd_q << DB))
						state_q <= S_UPD1;
					else
						state_q <= S_SDIV;
				end
				S_DONE: begin
					if (res_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				t_q  <= target[FB:0];
				m_q  <= m_in;
				a_q  <= '0;
				b_q  <= DB'(1);
				c_q  <= DB'(1);
				d_q  <= DB'(1);
				ii_q <= '0;
				if (target[TW-1]) begin
					rn_q <= '0;
					rd_q <= DB'(1);
					st_q <= ST_BELOW;
				end else begin
					rn_q <= DB'(1);
					rd_q <= DB'(1);
					st_q <= (target > (TW'(1) << FB)) ? ST_ABOVE : ST_OK;
				end
			end
			S_TB: if (launched_q && mul_sts.done) tb_q <= mul_prod;
			S_TD: if (launched_q && mul_sts.done) td_q <= mul_prod;
			S_CHECK: begin
				left_q <= sum_w < acf;
				if (sum_w < acf) begin
					rn_q  <= a_q;
					rd_q  <= b_q;
					qd_q  <= tb_q - af;
					num_q <= (cf <= td_q) ? '0 : cf - td_q;
				end else begin
					rn_q  <= c_q;
					rd_q  <= d_q;
					qd_q  <= cf - td_q;
					num_q <= (tb_q <= af) ? '0 : tb_q - af;
				end
			end
			S_CAP: if (launched_q && div_sts.done) cap_q <= div_quo;
			S_STEP: begin
				if (num_q == '0)
					n_q <= '0;
				else
					n_q <= cap_q;
			end
			S_SDIV: if (launched_q && div_sts.done) n_q <= n_sd;
			S_UPD1: begin
				if (launched_q && mul_sts.done) begin
					if (left_q)
						c_q <= c_q + mul_prod[DB-1:0];
					else
						a_q <= a_q + mul_prod[DB-1:0];
				end
			end
			S_UPD2: begin
				if (launched_q && mul_sts.done) begin
					if (left_q)
						d_q <= d_q + mul_prod[DB-1:0];
					else
						b_q <= b_q + mul_prod[DB-1:0];
					ii_q <= ii_q + 1'b1;
				end
			end
			S_FIN1: if (launched_q && mul_sts.done) lhs_q <= mul_prod << 1;
			S_FIN2: if (launched_q && mul_sts.done) s1_q <= mul_prod;
			S_FIN3: begin
				if (launched_q && mul_sts.done) begin
					if (lhs_q < rhs_w) begin
						rn_q <= a_q;
						rd_q <= b_q;
					end else begin
						rn_q <= c_q;
						rd_q <= d_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	fra_mul #(.PW(PW), .MB(MB)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mul_mc),
		.mplier (mul_mp),
		.prod   (mul_prod),
		.sts    (mul_sts)
	);

	fra_div #(.PW(PW), .QB(DB)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.quo      (div_quo),
		.rem      (div_rem),
		.sts      (div_sts)
	);

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res_num   = rn_q;
	assign res_den   = rd_q;
	assign res_iter  = ii_q[ITER_W-1:0];
	assign res_stat  = st_q;

endmodule

// File: hdl/farey_rational_approximation_top.sv
// Top level of the Farey rational approximation block: stream ports, register, output stage.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   target_fraction
//  m_axis    out  m_axis_tvalid/m_axis_tready   numerator, denominator, iteration_count, status
//  cfg       in   cfg_wen                       max_denominator
//
// One transaction at a time. An out-of-range target goes from idle straight to the done
// state, skipping the search, and then into the output register when that can take it.
// Each search iteration uses five shift-add multiplies and up to two restoring divides on
// the shared units, for up to MAX_ITER+1 iterations, followed by three multiplies for the
// final nearest-endpoint compare. Reset clears control state only, no clearing pass. A new
// target is taken while the previous result waits in the output register.
module farey_rational_approximation_top
	import fra_pkg::*;
#(
	parameter int DENOM_BITS = DENOM_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int MAX_ITER   = MAX_ITER_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [FRAC_BITS+2:0] target_fraction
	input  logic [((FRAC_BITS+3+7)/8)*8-1:0]       s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// numerator, denominator, iteration_count (7), status (2), lowest first
	output logic [((2*DENOM_BITS+9+7)/8)*8-1:0]    m_axis_tdata,
	input  logic                                   cfg_wen,
	input  logic [DENOM_BITS-1:0]                  cfg_wdata
);

	localparam int TW     = FRAC_BITS + 3;
	localparam int OUT_W  = 2 * DENOM_BITS + ITER_W + STAT_W;
	localparam int OUT_TW = ((2 * DENOM_BITS + 9 + 7) / 8) * 8;

	logic [DENOM_BITS-1:0] max_den_q;
	logic                  res_valid, res_ready;
	logic [DENOM_BITS-1:0] res_num, res_den;
	logic [ITER_W-1:0]     res_iter;
	logic [STAT_W-1:0]     res_stat;
	logic                  m_valid_q;
	logic [OUT_W-1:0]      m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_den_q <= {DENOM_BITS{1'b1}};
		else if (cfg_wen)
			max_den_q <= cfg_wdata;
	end

	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (res_ready)
			m_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			m_data_q <= {res_stat, res_iter, res_den, res_num};
	end

	fra_seq #(
		.DENOM_BITS (DENOM_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.MAX_ITER   (MAX_ITER)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.target    (s_axis_tdata[TW-1:0]),
		.max_den   (max_den_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_num   (res_num),
		.res_den   (res_den),
		.res_iter  (res_iter),
		.res_stat  (res_stat)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TW'(m_data_q);

endmodule

// File: hdl/fra_chk.sv
// Port-level checker for the Farey approximation top level, with its bind.
module fra_chk
	import fra_pkg::*;
#(
	parameter int DENOM_BITS = DENOM_BITS_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [((2*DENOM_BITS+9+7)/8)*8-1:0] m_axis_tdata
);

	localparam int DB = DENOM_BITS;

	logic [DB-1:0]     num, den;
	logic [ITER_W-1:0] iter;
	logic [STAT_W-1:0] stat;

	assign num  = m_axis_tdata[DB-1:0];
	assign den  = m_axis_tdata[2*DB-1:DB];
	assign iter = m_axis_tdata[2*DB+ITER_W-1:2*DB];
	assign stat = m_axis_tdata[2*DB+ITER_W+STAT_W-1:2*DB+ITER_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result transaction dropped or changed while stalled");

	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> den != '0)
		else $error("zero denominator");

	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && stat != ST_OK |->
			iter == '0 && den == DB'(1) &&
			((stat == ST_ABOVE && num == DB'(1)) || (stat == ST_BELOW && num == '0)))
		else $error("bad result for out-of-range target");

	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && stat == ST_OK |-> num <= den)
		else $error("fraction above one");

endmodule

bind farey_rational_approximation_top fra_chk #(.DENOM_BITS(DENOM_BITS)) u_fra_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
